>>> design/mbd_pkg.sv
// Shared constants for the mask border dilation block.
`default_nettype none
package mbd_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WEFF_W     = COL_W + 1;
	localparam int CFG_W      = 11;
	localparam int ROW_W      = 11;
	localparam int LINE_BITS  = 6;
	localparam int COL_BITS   = LINE_BITS + 1;
	localparam int WIN_BITS   = COL_BITS * COL_BITS;
	localparam int CENTER_BIT = (WIN_BITS - 1) / 2;
	localparam int HALF_WIN   = 3;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;
endpackage
`default_nettype wire

>>> design/mbd_ram.sv
// Generic single-port-write, registered-read memory.
`default_nettype none
module mbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> design/mask_border_dilation_top.sv
// Top level of the mask border dilation block: 7x7 window OR over a binary mask.
//
// Usage:
//  - Slave stream carries one mask byte per transfer in raster order; a byte of
//    128 or more is a mask pixel. Send frame_height+3 rows of frame_width pixels;
//    the three trailing rows only flush the window and their bytes are ignored.
//  - Master stream carries one result per transfer: tdata[0] is the conditioning
//    point flag (unmasked pixel with a mask pixel in its 7x7 window), tlast marks
//    the last result of one input transfer, tuser marks the frame's final pixel.
//  - The result for pixel (r,c) comes from input (r+3,c+3); the last input of a
//    row also emits the remaining pixels of row r-3, so an input gives 0 to 4
//    results, which pass through the stage 1 register and the output register.
//  - Throughput: one input per cycle while the output is not stalled, set by the
//    single line memory read-modify-write per pixel; the last column of a row
//    holds the input while the flush results drain from the output register.
//  - Configuration writes (frame_width, frame_height) restart the frame; write
//    them only while the block is idle.
//  - Reset clears the positions, the window and the pipeline; the line memory
//    needs no clearing pass because rows above row 0 are masked off.
//  - A stalled receiver holds the output register; the input stalls once the
//    single pipeline stage behind it is full.
`default_nettype none
module mask_border_dilation_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write port
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [mbd_pkg::CFG_W-1:0] cfg_data,
	// input stream
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [7:0]                s_axis_tdata,   // [7:0] mask_value
	// result stream
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic      [7:0]                m_axis_tdata,   // [0] conditioning_point
	output logic                           m_axis_tlast,   // last_of_run
	output logic                           m_axis_tuser    // [0] last_of_frame
);
	import mbd_pkg::*;

	// configuration and positions
	logic [CFG_W-1:0]     frame_width_q, frame_height_q;
	logic [WEFF_W-1:0]    w_eff;
	logic [ROW_W-1:0]     h_eff;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 in_xfer, out_xfer;
	logic                 at_last_col, at_last_row;
	logic [LINE_BITS-1:0] keep_mask;

	// stage 1: line memory read returns
	logic                 valid_s1, cur_s1, last_col_s1, emit_s1, last_row_s1, fwd_s1;
	logic [COL_W-1:0]     col_s1;
	logic [LINE_BITS-1:0] keep_s1, fwd_data_s1;

	// stage 2: output register with flush steps
	logic                 valid_s2, lof_s2;
	logic [1:0]           rem_s2;
	logic [WIN_BITS-1:0]  win_s2;

	logic [WIN_BITS-1:0]  win_q, win_next, win_pre;
	logic [LINE_BITS-1:0] ram_rdata, stored;
	logic [COL_BITS-1:0]  colvec;
	logic                 s2_free, s1_fire, col_ge3, any_result;
	logic [1:0]           first_step, rem_load;

	// clamp register values to the legal ranges
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (frame_width_q > CFG_W'(MAX_WIDTH)) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (frame_height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_W'(frame_height_q);
		end
	end

	assign in_xfer     = s_axis_tvalid && s_axis_tready;
	assign out_xfer    = m_axis_tvalid && m_axis_tready;
	assign at_last_col = ({1'b0, col_q} + WEFF_W'(1)) == w_eff;
	assign at_last_row = row_q == (h_eff + ROW_W'(2));

	// drop line memory bits of rows above row 0 of this frame
	always_comb begin
		for (int j = 0; j < LINE_BITS; j++) begin
			keep_mask[j] = row_q >= ROW_W'(LINE_BITS - j);
		end
	end

	// advance pixel position; any configuration write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(1024);
			frame_height_q <= CFG_W'(1024);
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end else begin
				frame_height_q <= cfg_data;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line memory: six previous rows of mask bits per column, oldest in bit 0
	mbd_ram #(
		.WIDTH(LINE_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(col_s1),
		.wdata(colvec[COL_BITS-1:1]),
		.re   (in_xfer),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	assign s2_free       = !valid_s2 || (m_axis_tready && rem_s2 == 2'd0);
	assign s1_fire       = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// forward the write-back when the same column is read at the same edge
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_s1      <= col_q;
			cur_s1      <= (row_q < h_eff) && s_axis_tdata[7];
			keep_s1     <= keep_mask;
			last_col_s1 <= at_last_col;
			last_row_s1 <= at_last_row;
			emit_s1     <= row_q >= ROW_W'(HALF_WIN);
			fwd_s1      <= s1_fire && (col_s1 == col_q);
			fwd_data_s1 <= colvec[COL_BITS-1:1];
		end
	end

	assign stored = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign colvec = {cur_s1, stored & keep_s1};

	// shift the new column into the window, cleared at the start of each row
	assign win_next = (col_s1 == '0) ? {{(WIN_BITS - COL_BITS){1'b0}}, colvec}
	                                 : {win_q[WIN_BITS-COL_BITS-1:0], colvec};

	assign col_ge3    = col_s1 >= COL_W'(HALF_WIN);
	assign any_result = emit_s1 && (col_ge3 || last_col_s1);
	assign first_step = col_ge3 ? 2'd0 : 2'(2'd3 - col_s1[1:0]);
	assign rem_load   = last_col_s1 ? 2'(2'd3 - first_step) : 2'd0;

	// skip flush steps whose pixel lies left of column 0 in narrow frames
	always_comb begin
		case (first_step)
			2'd0: win_pre = win_next;
			2'd1: win_pre = {win_next[WIN_BITS-COL_BITS-1:0], {COL_BITS{1'b0}}};
			2'd2: win_pre = {win_next[WIN_BITS-2*COL_BITS-1:0], {(2*COL_BITS){1'b0}}};
			default: win_pre = {win_next[WIN_BITS-3*COL_BITS-1:0], {(3*COL_BITS){1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			valid_s2 <= 1'b0;
			rem_s2   <= 2'd0;
		end else begin
			if (s1_fire) begin
				win_q    <= win_next;
				valid_s2 <= any_result;
				rem_s2   <= rem_load;
			end else if (out_xfer) begin
				if (rem_s2 == 2'd0) begin
					valid_s2 <= 1'b0;
				end else begin
					rem_s2 <= rem_s2 - 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			win_s2 <= win_pre;
			lof_s2 <= last_row_s1 && last_col_s1;
		end else if (out_xfer && rem_s2 != 2'd0) begin
			win_s2 <= {win_s2[WIN_BITS-COL_BITS-1:0], {COL_BITS{1'b0}}};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, (|win_s2) && !win_s2[CENTER_BIT]};
	assign m_axis_tlast  = rem_s2 == 2'd0;
	assign m_axis_tuser  = lof_s2 && (rem_s2 == 2'd0);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted pixel did not reach stage 1");

	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> (col_s1 == $past(col_s1) || $past(in_xfer)))
		else $error("forwarded line data without a matching read");

	a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_axis_tuser) |-> m_axis_tlast)
		else $error("frame end inside a run");

	a_stall_holds_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |=> (valid_s2 && rem_s2 == $past(rem_s2)))
		else $error("flush step lost while the receiver stalls");
endmodule
`default_nettype wire
